FILE: rtl/bsr_pkg.sv
// shared types, constants and helper functions for the block subsample reducer
`timescale 1ns / 1ps

package bsr_pkg;

    // block geometry
    localparam int MAX_SIDE = 8;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    // field widths
    localparam int PIX_W    = 16;
    localparam int SIDE_W   = 4;
    localparam int MODE_W   = 2;
    localparam int RANK_W   = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SUM_W    = PIX_W + IDX_W;

    // reciprocal used to split the pixel count into row and column
    localparam int RECIP_SHIFT = 12;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANK = 2'd2;

    // reduction modes
    localparam logic [MODE_W-1:0] MODE_AVG  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOW  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RANK = 2'd2;

    // reset values of the configuration registers
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_RANK;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 4'd2;
    localparam logic [RANK_W-1:0] RANK_RESET = 6'd1;

    // operation broadcast to every sort cell
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [PIX_W-1:0]   pix;
    } cell_ctl_t;

    // ceil(2^RECIP_SHIFT / side), exact quotient for counts below DEPTH
    function automatic logic [RECIP_W-1:0] side_recip(input logic [SIDE_W-1:0] side);
        logic [RECIP_W-1:0] r;
        begin
            case (side)
                4'd1:    r = 13'd4096;
                4'd2:    r = 13'd2048;
                4'd3:    r = 13'd1366;
                4'd4:    r = 13'd1024;
                4'd5:    r = 13'd820;
                4'd6:    r = 13'd683;
                4'd7:    r = 13'd586;
                4'd8:    r = 13'd512;
                default: r = 13'd4096;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: rtl/bsr_cell.sv
// one cell of the insertion sort chain: holds one value, inserts or shifts
`timescale 1ns / 1ps

module bsr_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bsr_pkg::cell_ctl_t         ctl,
    input  logic [bsr_pkg::PIX_W-1:0]  prev_value,
    input  logic                       prev_valid,
    input  logic                       prev_take,
    input  logic [bsr_pkg::PIX_W-1:0]  next_value,
    input  logic                       next_valid,
    output logic [bsr_pkg::PIX_W-1:0]  value,
    output logic                       valid,
    output logic                       take
);

    logic [bsr_pkg::PIX_W-1:0] value_reg;
    logic [bsr_pkg::PIX_W-1:0] value_next;
    logic                      valid_reg;
    logic                      valid_next;

    // new value goes at or before this cell
    assign take  = !valid_reg || (ctl.pix < value_reg);
    assign value = value_reg;
    assign valid = valid_reg;

    // next cell contents
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        case (ctl.op)
            bsr_pkg::CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            bsr_pkg::CELL_INSERT:
            begin
                if (take)
                begin
                    if (prev_take)
                    begin
                        value_next = prev_value;
                        valid_next = prev_valid;
                    end
                    else
                    begin
                        value_next = ctl.pix;
                        valid_next = 1'b1;
                    end
                end
            end
            bsr_pkg::CELL_SHIFT:
            begin
                value_next = next_value;
                valid_next = next_valid;
            end
            default:
            begin
                value_next = value_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // valid flag is control, value is payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

FILE: rtl/bsr_divider.sv
// restoring divider, one quotient bit per cycle, for the block average
`timescale 1ns / 1ps

module bsr_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bsr_pkg::SUM_W-1:0]  dividend,
    input  logic [bsr_pkg::CNT_W-1:0]  divisor,
    output logic                       done,
    output logic [bsr_pkg::SUM_W-1:0]  quotient
);

    localparam int STEP_W = $clog2(bsr_pkg::SUM_W + 1);

    logic [bsr_pkg::SUM_W-1:0] quot_reg;
    logic [bsr_pkg::SUM_W-1:0] quot_next;
    logic [bsr_pkg::CNT_W-1:0] rem_reg;
    logic [bsr_pkg::CNT_W-1:0] rem_next;
    logic [bsr_pkg::CNT_W-1:0] dvs_reg;
    logic [bsr_pkg::CNT_W-1:0] dvs_next;
    logic [STEP_W-1:0]         step_reg;
    logic [STEP_W-1:0]         step_next;
    logic                      busy_reg;
    logic                      busy_next;
    logic                      done_reg;
    logic                      done_next;
    logic [bsr_pkg::CNT_W:0]   trial;

    assign trial    = {rem_reg, quot_reg[bsr_pkg::SUM_W-1]};
    assign done     = done_reg;
    assign quotient = quot_reg;

    // one shift and subtract step per cycle
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = STEP_W'(bsr_pkg::SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next  = bsr_pkg::CNT_W'(trial - {1'b0, dvs_reg});
                quot_next = {quot_reg[bsr_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[bsr_pkg::CNT_W-1:0];
                quot_next = {quot_reg[bsr_pkg::SUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

endmodule

FILE: rtl/block_subsample_reducer_unit.sv
// top level: pixel store, insertion sort cell chain, sequencer and result register
// after the last pixel of a block: lowest mode loads the result directly, rank mode
//   replays the store and shifts to the clamped rank, average mode replays and divides
// throughput: one pixel per cycle inside a block; pixel_ready drops from the last
//   pixel until the block result sits in the output register (store replay, chain
//   shifts and the 22-step divider set this gap)
// reset: registers return to mode rank, side 2, rank 1; counters and chain cleared
`timescale 1ns / 1ps

module block_subsample_reducer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    output logic                            pixel_ready,
    input  logic [bsr_pkg::PIX_W-1:0]       pixel_value,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [bsr_pkg::PIX_W-1:0]       reduced_value,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bsr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bsr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        S_FILL,
        S_REPLAY,
        S_SHIFT,
        S_DIV,
        S_LOAD
    } state_t;

    // configuration registers
    logic [bsr_pkg::MODE_W-1:0] mode_reg;
    logic [bsr_pkg::SIDE_W-1:0] side_reg;
    logic [bsr_pkg::RANK_W-1:0] rank_reg;

    // control and payload registers
    state_t                     state_reg, state_next;
    logic [bsr_pkg::IDX_W-1:0]  count_reg, count_next;
    logic [bsr_pkg::PIX_W-1:0]  smin_reg, smin_next;
    logic [bsr_pkg::CNT_W-1:0]  n_reg, n_next;
    logic [bsr_pkg::MODE_W-1:0] bmode_reg, bmode_next;
    logic [bsr_pkg::IDX_W-1:0]  k_reg, k_next;
    logic [bsr_pkg::CNT_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic                       rd_vld_reg, rd_vld_next;
    logic [bsr_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [bsr_pkg::PIX_W-1:0]  res_reg, res_next;
    logic                       out_valid_reg, out_valid_next;
    logic [bsr_pkg::PIX_W-1:0]  out_value_reg, out_value_next;

    // pixel store
    logic [bsr_pkg::PIX_W-1:0]  store_mem [bsr_pkg::DEPTH];
    logic [bsr_pkg::PIX_W-1:0]  rd_data_reg;

    // geometry of the current pixel
    logic [bsr_pkg::SIDE_W-1:0]             side_eff;
    logic [2*bsr_pkg::SIDE_W-1:0]           n_full;
    logic [bsr_pkg::CNT_W-1:0]              n_cur;
    logic [bsr_pkg::IDX_W+bsr_pkg::RECIP_W-1:0] qprod;
    logic [bsr_pkg::IDX_W-1:0]              row;
    logic [bsr_pkg::IDX_W+bsr_pkg::SIDE_W-1:0]  row_base;
    logic [bsr_pkg::IDX_W-1:0]              col;
    logic [bsr_pkg::IDX_W-1:0]              half;
    logic                                   is_sample;
    logic [bsr_pkg::PIX_W-1:0]              smin_upd;
    logic [bsr_pkg::CNT_W-1:0]              count_inc;
    logic                                   pix_fire;
    logic                                   complete;
    logic                                   rd_issue;
    logic [bsr_pkg::CNT_W-1:0]              rank_ext;

    // sort chain wiring
    bsr_pkg::cell_ctl_t                     chain_ctl;
    logic [bsr_pkg::PIX_W-1:0]              cell_value [bsr_pkg::DEPTH];
    logic [bsr_pkg::DEPTH-1:0]              cell_valid;
    logic [bsr_pkg::DEPTH-1:0]              cell_take;

    // divider
    logic                                   div_start;
    logic                                   div_done;
    logic [bsr_pkg::SUM_W-1:0]              div_quot;

    assign pixel_ready   = (state_reg == S_FILL);
    assign cfg_ready     = 1'b1;
    assign result_valid  = out_valid_reg;
    assign reduced_value = out_value_reg;

    // side clamped to 1..MAX_SIDE and block size
    always_comb
    begin
        if (side_reg == '0)
        begin
            side_eff = bsr_pkg::SIDE_W'(1);
        end
        else if (side_reg > bsr_pkg::SIDE_W'(bsr_pkg::MAX_SIDE))
        begin
            side_eff = bsr_pkg::SIDE_W'(bsr_pkg::MAX_SIDE);
        end
        else
        begin
            side_eff = side_reg;
        end
    end

    assign n_full = side_eff * side_eff;
    assign n_cur  = n_full[bsr_pkg::CNT_W-1:0];

    // row and column of the incoming pixel by reciprocal multiply
    assign qprod    = count_reg * bsr_pkg::side_recip(side_eff);
    assign row      = qprod[bsr_pkg::RECIP_SHIFT +: bsr_pkg::IDX_W];
    assign row_base = row * side_eff;
    assign col      = count_reg - row_base[bsr_pkg::IDX_W-1:0];
    assign half     = bsr_pkg::IDX_W'(side_eff >> 1);

    assign is_sample = ((row == '0) || (row == half)) && ((col == '0) || (col == half));
    assign smin_upd  = (is_sample && (pixel_value < smin_reg)) ? pixel_value : smin_reg;

    assign pix_fire  = pixel_valid && pixel_ready;
    assign count_inc = {1'b0, count_reg} + 1'b1;
    assign complete  = pix_fire && (count_inc >= n_cur);
    assign rd_issue  = (rd_cnt_reg < n_reg);
    assign rank_ext  = bsr_pkg::CNT_W'(rank_reg);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        smin_next      = smin_reg;
        n_next         = n_reg;
        bmode_next     = bmode_reg;
        k_next         = k_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_vld_next    = 1'b0;
        sum_next       = sum_reg;
        res_next       = res_reg;
        out_value_next = out_value_reg;
        out_valid_next = out_valid_reg && !result_ready;
        chain_ctl.op   = bsr_pkg::CELL_HOLD;
        chain_ctl.pix  = rd_data_reg;
        div_start      = 1'b0;
        case (state_reg)
            S_FILL:
            begin
                if (pix_fire)
                begin
                    if (complete)
                    begin
                        count_next   = '0;
                        smin_next    = '1;
                        n_next       = n_cur;
                        bmode_next   = mode_reg;
                        rd_cnt_next  = '0;
                        sum_next     = '0;
                        chain_ctl.op = bsr_pkg::CELL_CLEAR;
                        if (rank_ext >= n_cur)
                        begin
                            k_next = bsr_pkg::IDX_W'(n_cur - 1'b1);
                        end
                        else
                        begin
                            k_next = bsr_pkg::IDX_W'(rank_ext);
                        end
                        if (mode_reg == bsr_pkg::MODE_LOW)
                        begin
                            res_next   = smin_upd;
                            state_next = S_LOAD;
                        end
                        else
                        begin
                            state_next = S_REPLAY;
                        end
                    end
                    else
                    begin
                        count_next = count_inc[bsr_pkg::IDX_W-1:0];
                        smin_next  = smin_upd;
                    end
                end
            end
            S_REPLAY:
            begin
                // read the store in arrival order, insert and add
                rd_vld_next = rd_issue;
                if (rd_issue)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    chain_ctl.op = bsr_pkg::CELL_INSERT;
                    sum_next     = sum_reg + bsr_pkg::SUM_W'(rd_data_reg);
                end
                if (!rd_issue && !rd_vld_reg)
                begin
                    if (bmode_reg == bsr_pkg::MODE_AVG)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                // walk the sorted chain down to the chosen rank
                if (k_reg == '0)
                begin
                    res_next   = cell_value[0];
                    state_next = S_LOAD;
                end
                else
                begin
                    chain_ctl.op = bsr_pkg::CELL_SHIFT;
                    k_next       = k_reg - 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_quot[bsr_pkg::PIX_W-1:0];
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_value_next = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_FILL;
                end
            end
            default:
            begin
                state_next = S_FILL;
            end
        endcase
    end

    // state, configuration and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            count_reg     <= '0;
            smin_reg      <= '1;
            rd_cnt_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            k_reg         <= '0;
            n_reg         <= '0;
            bmode_reg     <= bsr_pkg::MODE_RESET;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            mode_reg      <= bsr_pkg::MODE_RESET;
            side_reg      <= bsr_pkg::SIDE_RESET;
            rank_reg      <= bsr_pkg::RANK_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            smin_reg      <= smin_next;
            rd_cnt_reg    <= rd_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            bmode_reg     <= bmode_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bsr_pkg::REG_MODE: mode_reg <= cfg_data[bsr_pkg::MODE_W-1:0];
                    bsr_pkg::REG_SIDE: side_reg <= cfg_data[bsr_pkg::SIDE_W-1:0];
                    bsr_pkg::REG_RANK: rank_reg <= cfg_data[bsr_pkg::RANK_W-1:0];
                    default:
                    begin
                        mode_reg <= mode_reg;
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sum_reg       <= sum_next;
        res_reg       <= res_next;
    end

    // pixel store: write on pixel transfer, registered read for replay
    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            store_mem[count_reg] <= pixel_value;
        end
        rd_data_reg <= store_mem[rd_cnt_reg[bsr_pkg::IDX_W-1:0]];
    end

    // insertion sort cell chain
    genvar gi;
    generate
        for (gi = 0; gi < bsr_pkg::DEPTH; gi++)
        begin : g_cell
            logic [bsr_pkg::PIX_W-1:0] prev_value;
            logic                      prev_valid;
            logic                      prev_take;
            logic [bsr_pkg::PIX_W-1:0] next_value;
            logic                      next_valid;

            if (gi == 0)
            begin : g_first
                assign prev_value = '0;
                assign prev_valid = 1'b0;
                assign prev_take  = 1'b0;
            end
            else
            begin : g_inner
                assign prev_value = cell_value[gi-1];
                assign prev_valid = cell_valid[gi-1];
                assign prev_take  = cell_take[gi-1];
            end

            if (gi == bsr_pkg::DEPTH - 1)
            begin : g_last
                assign next_value = '0;
                assign next_valid = 1'b0;
            end
            else
            begin : g_body
                assign next_value = cell_value[gi+1];
                assign next_valid = cell_valid[gi+1];
            end

            bsr_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (chain_ctl),
                .prev_value (prev_value),
                .prev_valid (prev_valid),
                .prev_take  (prev_take),
                .next_value (next_value),
                .next_valid (next_valid),
                .value      (cell_value[gi]),
                .valid      (cell_valid[gi]),
                .take       (cell_take[gi])
            );
        end
    endgenerate

    // divider for the block mean
    bsr_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

`ifndef SYNTHESIS
    // chain valid cells always form a prefix starting at cell zero
    a_chain_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_valid + 1'b1))
        else $error("sort chain valid cells are not contiguous");

    // during replay the chain holds exactly the pixels already inserted
    a_chain_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REPLAY) |->
            ($countones(cell_valid) == int'(rd_cnt_reg) - int'(rd_vld_reg)))
        else $error("sort chain occupancy does not match replay count");

    // no pixel is taken right after the last pixel of a block
    a_block_stall: assert property (@(posedge clk) disable iff (!rst_n)
        complete |=> !pixel_ready)
        else $error("pixel taken while block result is pending");

    // divider only finishes while the sequencer waits for it
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the average step");
`endif

endmodule

FILE: tb/reduction_checker.sv
// checker for the block subsample reducer: predicts each block reduction and compares results
`timescale 1ns / 1ps

module reduction_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pixel_valid,
    input  logic                             pixel_ready,
    input  logic [bsr_pkg::PIX_W-1:0]        pixel_value,
    input  logic                             result_valid,
    input  logic                             result_ready,
    input  logic [bsr_pkg::PIX_W-1:0]        reduced_value,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [bsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bsr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                               mismatch_count,
    output int                               results_owed
);

    // shadow copy of the configuration registers
    logic [bsr_pkg::MODE_W-1:0] cur_mode;
    logic [bsr_pkg::SIDE_W-1:0] cur_side;
    logic [bsr_pkg::RANK_W-1:0] cur_rank;

    // shadow copy of the block state
    logic [bsr_pkg::PIX_W-1:0]  pixel_log [bsr_pkg::DEPTH];
    logic [bsr_pkg::SUM_W-1:0]  running_total;
    logic [bsr_pkg::PIX_W-1:0]  sample_floor;
    logic [bsr_pkg::CNT_W-1:0]  fill;

    // reductions waiting for their result transfer
    logic [bsr_pkg::PIX_W-1:0]  expected_reductions [$];

    // take one pixel into the shadow block, queue the reduction when the block completes
    task automatic fold_pixel(input logic [bsr_pkg::PIX_W-1:0] pix);
        int s;
        int n;
        int half;
        int row;
        int col;
        int k;
        int i;
        int j;
        logic [bsr_pkg::PIX_W-1:0] ordered [bsr_pkg::DEPTH];
        logic [bsr_pkg::PIX_W-1:0] v;
        logic [bsr_pkg::PIX_W-1:0] outcome;
        begin
            // side 0 acts as 1, oversize sides act as the largest block
            if (cur_side == '0)
                s = 1;
            else if (int'(cur_side) > bsr_pkg::MAX_SIDE)
                s = bsr_pkg::MAX_SIDE;
            else
                s = int'(cur_side);
            n = s * s;
            half = s / 2;

            if (int'(fill) >= bsr_pkg::DEPTH)
                fill = bsr_pkg::CNT_W'(bsr_pkg::DEPTH - 1);
            row = int'(fill) / s;
            col = int'(fill) % s;
            pixel_log[fill[bsr_pkg::IDX_W-1:0]] = pix;
            running_total = running_total + bsr_pkg::SUM_W'(pix);
            if ((row == 0 || row == half) && (col == 0 || col == half) && pix < sample_floor)
                sample_floor = pix;
            fill = fill + 1'b1;

            if (int'(fill) >= n)
            begin
                case (cur_mode)
                    bsr_pkg::MODE_AVG: outcome = bsr_pkg::PIX_W'(int'(running_total) / n);
                    bsr_pkg::MODE_LOW: outcome = sample_floor;
                    // rank mode, the spare code falls here too
                    default:
                    begin
                        for (i = 0; i < n; i++)
                        begin
                            v = pixel_log[bsr_pkg::IDX_W'(i)];
                            j = i;
                            while (j > 0
                                   && ordered[bsr_pkg::IDX_W'((j > 0) ? j - 1 : 0)] > v)
                            begin
                                ordered[bsr_pkg::IDX_W'(j)] = ordered[bsr_pkg::IDX_W'(j - 1)];
                                j--;
                            end
                            ordered[bsr_pkg::IDX_W'(j)] = v;
                        end
                        // oversized rank clamps to the largest pixel
                        k = (int'(cur_rank) >= n) ? n - 1 : int'(cur_rank);
                        outcome = ordered[bsr_pkg::IDX_W'(k)];
                    end
                endcase
                expected_reductions.push_back(outcome);
                running_total = '0;
                sample_floor = '1;
                fill = '0;
            end
        end
    endtask

    // watch all three channels at every edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mode = bsr_pkg::MODE_RESET;
            cur_side = bsr_pkg::SIDE_RESET;
            cur_rank = bsr_pkg::RANK_RESET;
            running_total = '0;
            sample_floor = '1;
            fill = '0;
            expected_reductions.delete();
            mismatch_count = 0;
            results_owed = 0;
        end
        else
        begin
            // register write transfer
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bsr_pkg::REG_MODE: cur_mode = cfg_data[bsr_pkg::MODE_W-1:0];
                    bsr_pkg::REG_SIDE: cur_side = cfg_data[bsr_pkg::SIDE_W-1:0];
                    bsr_pkg::REG_RANK: cur_rank = cfg_data[bsr_pkg::RANK_W-1:0];
                    default: ;
                endcase
            end

            // result transfer against the oldest expectation
            if (result_valid && result_ready)
            begin
                if (expected_reductions.size() == 0)
                begin
                    $error("reduced_value: no result expected, actual %0d", reduced_value);
                    mismatch_count++;
                end
                else if (reduced_value !== expected_reductions[0])
                begin
                    $error("reduced_value: expected %0d, actual %0d",
                           expected_reductions[0], reduced_value);
                    mismatch_count++;
                    void'(expected_reductions.pop_front());
                end
                else
                    void'(expected_reductions.pop_front());
            end

            // pixel transfer
            if (pixel_valid && pixel_ready)
                fold_pixel(pixel_value);

            results_owed = expected_reductions.size();
        end
    end

endmodule

FILE: tb/tb.sv
// testbench top: clock, reset, pixel and register stimulus, result sink and verdict
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 150;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_PIXELS  = 350;
    localparam logic [bsr_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            pixel_valid = 1'b0;
    logic                            pixel_ready;
    logic [bsr_pkg::PIX_W-1:0]       pixel_value = '0;
    logic                            result_valid;
    logic                            result_ready = 1'b0;
    logic [bsr_pkg::PIX_W-1:0]       reduced_value;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [bsr_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [bsr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    int mismatch_count;
    int results_owed;

    // idle percentages for the two sides
    int send_idle = 0;
    int recv_stall = 0;

    // long receiver hold-off requests
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;

    int quiet_cycles = 0;

    block_subsample_reducer_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel_valid   (pixel_valid),
        .pixel_ready   (pixel_ready),
        .pixel_value   (pixel_value),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .reduced_value (reduced_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    reduction_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .pixel_valid    (pixel_valid),
        .pixel_ready    (pixel_ready),
        .pixel_value    (pixel_value),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .reduced_value  (reduced_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // result sink with random stalls and counted hold-offs
    always @(posedge clk)
    begin
        if (holds_served != holds_asked)
        begin
            holds_served <= holds_asked;
            hold_left <= HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_stall);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (pixel_valid && pixel_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[block_subsample_reducer_unit] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // one pixel transfer, with a random gap in front of it
    task automatic send_pixel(input logic [bsr_pkg::PIX_W-1:0] v);
        logic acc;
        begin
            if ($urandom_range(99) < send_idle)
            begin
                pixel_valid <= 1'b0;
                do @(posedge clk); while ($urandom_range(99) < send_idle);
            end
            pixel_valid <= 1'b1;
            pixel_value <= v;
            do
            begin
                @(negedge clk);
                acc = pixel_ready;
                @(posedge clk);
            end
            while (!acc);
        end
    endtask

    // stop sending, wait for every owed result, then let the pipeline go quiet
    task automatic settle();
        begin
            pixel_valid <= 1'b0;
            do @(negedge clk); while (results_owed != 0);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    // write all three registers back to back while the block is idle
    task automatic configure(input logic [bsr_pkg::MODE_W-1:0] mode,
                             input logic [bsr_pkg::SIDE_W-1:0] side,
                             input logic [bsr_pkg::RANK_W-1:0] rank);
        logic acc;
        int i;
        begin
            settle();
            for (i = 0; i < 3; i++)
            begin
                cfg_valid <= 1'b1;
                case (i)
                    0:
                    begin
                        cfg_index <= bsr_pkg::REG_MODE;
                        cfg_data <= bsr_pkg::CFG_DATA_W'(mode);
                    end
                    1:
                    begin
                        cfg_index <= bsr_pkg::REG_SIDE;
                        cfg_data <= bsr_pkg::CFG_DATA_W'(side);
                    end
                    default:
                    begin
                        cfg_index <= bsr_pkg::REG_RANK;
                        cfg_data <= bsr_pkg::CFG_DATA_W'(rank);
                    end
                endcase
                do
                begin
                    @(negedge clk);
                    acc = cfg_ready;
                    @(posedge clk);
                end
                while (!acc);
            end
            cfg_valid <= 1'b0;
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int phase;
        int random_pixels;
        int s;
        int n;
        int blocks;
        int b;
        int p;
        int pick;
        logic [bsr_pkg::MODE_W-1:0] m;
        logic [bsr_pkg::SIDE_W-1:0] sd;
        logic [bsr_pkg::RANK_W-1:0] rk;
        logic [bsr_pkg::PIX_W-1:0]  pv;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: rank 1 of a 2x2 block
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        send_pixel(16'h0001);
        send_pixel(16'hFFFE);

        // side 0 acts as 1, one pixel per block in each mode
        configure(bsr_pkg::MODE_AVG, 4'd0, 6'd63);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        configure(bsr_pkg::MODE_LOW, 4'd0, 6'd63);
        send_pixel(16'd12345);
        // rank far above the block size
        configure(bsr_pkg::MODE_RANK, 4'd0, 6'd63);
        send_pixel(16'd40000);

        // average of an all-ones block, widest sum per pixel
        configure(bsr_pkg::MODE_AVG, 4'd2, 6'd0);
        repeat (4) send_pixel(16'hFFFF);

        // lowest of samples while smaller pixels sit off the sample grid
        configure(bsr_pkg::MODE_LOW, 4'd3, 6'd5);
        send_pixel(16'd900);
        send_pixel(16'd700);
        send_pixel(16'd5);
        send_pixel(16'd800);
        send_pixel(16'd650);
        send_pixel(16'd3);
        send_pixel(16'd2);
        send_pixel(16'd1);
        send_pixel(16'd0);

        // spare mode code behaves as rank, rank zero gives the minimum
        configure(MODE_SPARE, 4'd2, 6'd0);
        send_pixel(16'd7);
        send_pixel(16'd3);
        send_pixel(16'd3);
        send_pixel(16'd9);

        // random phases
        phase = 0;
        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS)
        begin
            case (phase)
                0:
                begin
                    m = bsr_pkg::MODE_AVG;
                    sd = 4'd8;
                    rk = 6'd0;
                end
                1:
                begin
                    m = bsr_pkg::MODE_RANK;
                    sd = 4'd15;
                    rk = 6'd63;
                end
                2:
                begin
                    m = bsr_pkg::MODE_LOW;
                    sd = 4'd5;
                    rk = 6'd20;
                end
                3:
                begin
                    m = bsr_pkg::MODE_W'($urandom_range(3));
                    sd = 4'd2;
                    rk = bsr_pkg::RANK_W'($urandom_range(3));
                end
                default:
                begin
                    m = bsr_pkg::MODE_W'($urandom_range(3));
                    pick = $urandom_range(19);
                    if (pick < 14)
                        sd = bsr_pkg::SIDE_W'($urandom_range(1, 4));
                    else if (pick < 17)
                        sd = bsr_pkg::SIDE_W'($urandom_range(5, 8));
                    else if (pick == 17)
                        sd = 4'd0;
                    else
                        sd = bsr_pkg::SIDE_W'($urandom_range(9, 15));
                    pick = $urandom_range(3);
                    if (pick == 0)
                        rk = 6'd0;
                    else if (pick == 1)
                        rk = 6'd63;
                    else
                        rk = bsr_pkg::RANK_W'($urandom_range(0,
                                 (sd > 4'd7) ? 63 : int'(sd) * int'(sd)));
                end
            endcase
            configure(m, sd, rk);

            if (sd == '0)
                s = 1;
            else if (int'(sd) > bsr_pkg::MAX_SIDE)
                s = bsr_pkg::MAX_SIDE;
            else
                s = int'(sd);
            n = s * s;
            blocks = (n <= 16) ? $urandom_range(2, 6) : 1;

            // idle pattern rotates over the phases
            case (phase % 4)
                0:
                begin
                    send_idle = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle = 82;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle = 0;
                    recv_stall = 82;
                end
                default:
                begin
                    send_idle = 8;
                    recv_stall = 8;
                end
            endcase

            // receiver holds off while the sender keeps offering pixels
            if (phase == 3)
            begin
                send_idle = 0;
                blocks = 6;
                holds_asked = holds_asked + 1;
            end

            for (b = 0; b < blocks; b++)
            begin
                for (p = 0; p < n; p++)
                begin
                    pick = $urandom_range(9);
                    if (pick < 5)
                        pv = bsr_pkg::PIX_W'($urandom);
                    else if (pick < 8)
                        pv = bsr_pkg::PIX_W'($urandom_range(7));
                    else
                        pv = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
                    send_pixel(pv);
                    random_pixels++;
                end
                // sender pauses until the first block's result is back
                if (phase == 5 && b == 0)
                    settle();
            end
            phase++;
        end

        settle();
        if (mismatch_count == 0)
            $display("[block_subsample_reducer_unit] OK");
        else
            $display("[block_subsample_reducer_unit] ERROR");
        $finish;
    end

endmodule
